FILE: rtl/core/rhp_pkg.sv
package rhp_pkg;

    localparam int MAX_PACKET_BYTES = 2048;
    localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam int START_W = 19;
    localparam int PLEN_W = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 7;
    localparam int OUT_DATA_W = 112;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_PAYLOAD = 2'd0;
    localparam kind_t KIND_CSRC    = 2'd1;
    localparam kind_t KIND_SUMMARY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SWAP_TYPE_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_TYPE_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_TYPE_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_ENABLE = 3'd3;

    localparam logic [1:0] HDR_VERSION = 2'd2;

    typedef struct packed {
        logic [6:0] swap_type_a;
        logic [6:0] swap_type_b;
        logic [6:0] swap_type_c;
        logic       swap_enable;
    } cfg_t;

    typedef struct packed {
        logic [31:0]       ssrc;
        logic [15:0]       seq_num;
        logic [31:0]       timestamp;
        logic [6:0]        media_type;
        logic              marker;
        logic [3:0]        source_count;
        logic              has_extension;
        logic              padded;
        logic [PLEN_W-1:0] payload_length;
        logic              packet_valid;
    } summary_t;

    // up to two leading items (the second is always a payload byte), then an optional summary
    typedef struct packed {
        logic [1:0]  small_cnt;
        kind_t       s0_kind;
        logic [31:0] s0_data;
        logic [7:0]  s1_data;
        logic        sum_vld;
        summary_t    sum;
    } bundle_t;

endpackage

FILE: rtl/core/rhp_parse.sv
module rhp_parse
(
    input  logic             clk,
    input  logic             rst_n,
    input  rhp_pkg::cfg_t    cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_byte,
    input  logic             in_eop,
    output logic             bnd_load,
    input  logic             bnd_ready,
    output rhp_pkg::bundle_t bnd
);
    import rhp_pkg::*;

    logic               in_vld_reg;
    logic [7:0]         in_byte_reg;
    logic               in_eop_reg;

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [31:0]        word_reg, word_next;
    logic [7:0]         first_reg, first_next;
    logic [7:0]         second_reg, second_next;
    logic [15:0]        seq_reg, seq_next;
    logic [31:0]        ts_reg, ts_next;
    logic [31:0]        ssrc_reg, ssrc_next;
    logic [START_W-1:0] pstart_reg, pstart_next;
    logic               pend_vld_reg, pend_vld_next;
    logic [7:0]         pend_reg, pend_next;
    logic               ovf_reg, ovf_next;

    logic               step_en;
    logic               has_items;
    logic [START_W-1:0] p_ext;
    logic [START_W-1:0] csrc_end;
    logic [START_W-1:0] len;
    logic [START_W-1:0] plen;
    logic [15:0]        ext_words;
    logic [6:0]         pt;
    logic               swap;
    logic               valid;
    logic [7:0]         b;
    bundle_t            bnd_c;

    assign b = in_byte_reg;

    always_comb
    begin
        pos_next      = pos_reg;
        word_next     = word_reg;
        first_next    = first_reg;
        second_next   = second_reg;
        seq_next      = seq_reg;
        ts_next       = ts_reg;
        ssrc_next     = ssrc_reg;
        pstart_next   = pstart_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        ovf_next      = ovf_reg;
        bnd_c         = '0;
        p_ext         = START_W'(pos_reg);
        csrc_end      = START_W'(12) + START_W'({first_reg[3:0], 2'b00});
        ext_words     = {word_reg[7:0], b};
        pt            = second_reg[6:0];
        swap          = cfg.swap_enable && (pt == cfg.swap_type_a || pt == cfg.swap_type_b
                        || pt == cfg.swap_type_c);

        if (pos_reg >= POS_W'(MAX_PACKET_BYTES))
        begin
            ovf_next = 1'b1;
        end
        else
        begin
            pos_next = pos_reg + POS_W'(1);
            if (p_ext == START_W'(0))
            begin
                first_next  = b;
                pstart_next = START_W'(12) + START_W'({b[3:0], 2'b00})
                              + (b[4] ? START_W'(4) : START_W'(0));
            end
            else if (p_ext == START_W'(1))
            begin
                second_next = b;
            end
            else if (p_ext < START_W'(4))
            begin
                seq_next = {seq_reg[7:0], b};
            end
            else if (p_ext < START_W'(8))
            begin
                ts_next = {ts_reg[23:0], b};
            end
            else if (p_ext < START_W'(12))
            begin
                ssrc_next = {ssrc_reg[23:0], b};
            end
            else if (p_ext < csrc_end)
            begin
                word_next = {word_reg[23:0], b};
                if (pos_reg[1:0] == 2'd3)
                begin
                    bnd_c.small_cnt = 2'd1;
                    bnd_c.s0_kind   = KIND_CSRC;
                    bnd_c.s0_data   = {word_reg[23:0], b};
                    word_next       = '0;
                end
            end
            else if (p_ext < pstart_reg)
            begin
                if (first_reg[4] && p_ext >= csrc_end + START_W'(2)
                    && p_ext <= csrc_end + START_W'(3))
                begin
                    word_next = {16'd0, ext_words};
                    if (p_ext == csrc_end + START_W'(3))
                    begin
                        pstart_next = pstart_reg + START_W'({ext_words, 2'b00});
                        word_next   = '0;
                    end
                end
            end
            else if (swap)
            begin
                if (pend_vld_reg)
                begin
                    bnd_c.small_cnt = 2'd2;
                    bnd_c.s0_kind   = KIND_PAYLOAD;
                    bnd_c.s0_data   = {24'd0, b};
                    bnd_c.s1_data   = pend_reg;
                    pend_vld_next   = 1'b0;
                end
                else
                begin
                    pend_vld_next = 1'b1;
                    pend_next     = b;
                end
            end
            else
            begin
                bnd_c.small_cnt = 2'd1;
                bnd_c.s0_kind   = KIND_PAYLOAD;
                bnd_c.s0_data   = {24'd0, b};
            end
        end

        len   = START_W'(pos_next);
        plen  = (len > pstart_next) ? len - pstart_next : '0;
        valid = first_next[7:6] == HDR_VERSION && len >= pstart_next && !ovf_next
                && !(first_next[5] && START_W'(b) >= plen);

        if (in_eop_reg)
        begin
            if (pend_vld_next)
            begin
                if (bnd_c.small_cnt == 2'd0)
                begin
                    bnd_c.s0_kind = KIND_PAYLOAD;
                    bnd_c.s0_data = {24'd0, pend_next};
                end
                else
                begin
                    bnd_c.s1_data = pend_next;
                end
                bnd_c.small_cnt = bnd_c.small_cnt + 2'd1;
            end
            bnd_c.sum_vld            = 1'b1;
            bnd_c.sum.ssrc           = ssrc_next;
            bnd_c.sum.seq_num        = seq_next;
            bnd_c.sum.timestamp      = ts_next;
            bnd_c.sum.media_type     = second_next[6:0];
            bnd_c.sum.marker         = second_next[7];
            bnd_c.sum.source_count   = first_next[3:0];
            bnd_c.sum.has_extension  = first_next[4];
            bnd_c.sum.padded         = first_next[5];
            bnd_c.sum.payload_length = plen[PLEN_W-1:0];
            bnd_c.sum.packet_valid   = valid;
        end
    end

    assign has_items = (bnd_c.small_cnt != 2'd0) || in_eop_reg;
    assign step_en   = in_vld_reg && (!has_items || bnd_ready);
    assign in_ready  = !in_vld_reg || step_en;
    assign bnd_load  = step_en && has_items;
    assign bnd       = bnd_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= in_byte;
            in_eop_reg  <= in_eop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            word_reg     <= '0;
            first_reg    <= '0;
            second_reg   <= '0;
            seq_reg      <= '0;
            ts_reg       <= '0;
            ssrc_reg     <= '0;
            pstart_reg   <= START_W'(12);
            pend_vld_reg <= 1'b0;
            pend_reg     <= '0;
            ovf_reg      <= 1'b0;
        end
        else if (step_en)
        begin
            if (in_eop_reg)
            begin
                pos_reg      <= '0;
                word_reg     <= '0;
                first_reg    <= '0;
                second_reg   <= '0;
                seq_reg      <= '0;
                ts_reg       <= '0;
                ssrc_reg     <= '0;
                pstart_reg   <= START_W'(12);
                pend_vld_reg <= 1'b0;
                pend_reg     <= '0;
                ovf_reg      <= 1'b0;
            end
            else
            begin
                pos_reg      <= pos_next;
                word_reg     <= word_next;
                first_reg    <= first_next;
                second_reg   <= second_next;
                seq_reg      <= seq_next;
                ts_reg       <= ts_next;
                ssrc_reg     <= ssrc_next;
                pstart_reg   <= pstart_next;
                pend_vld_reg <= pend_vld_next;
                pend_reg     <= pend_next;
                ovf_reg      <= ovf_next;
            end
        end
    end

endmodule

FILE: rtl/core/rhp_out.sv
module rhp_out
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               bnd_load,
    output logic                               bnd_ready,
    input  rhp_pkg::bundle_t                   bnd,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rhp_pkg::OUT_DATA_W-1:0]     m_tdata,
    output rhp_pkg::kind_t                     m_tuser,
    output logic                               m_tlast
);
    import rhp_pkg::*;

    bundle_t    bnd_reg;
    logic       busy_reg;
    logic [1:0] idx_reg;
    logic [1:0] total;
    logic       last_item;
    logic       is_small;

    assign total     = bnd_reg.small_cnt + {1'b0, bnd_reg.sum_vld};
    assign last_item = (idx_reg + 2'd1) == total;
    assign is_small  = idx_reg < bnd_reg.small_cnt;
    assign bnd_ready = !busy_reg || (m_tready && last_item);
    assign m_tvalid  = busy_reg;

    always_comb
    begin
        m_tdata = '0;
        m_tuser = KIND_PAYLOAD;
        m_tlast = 1'b0;
        if (is_small)
        begin
            if (idx_reg == 2'd0)
            begin
                m_tuser       = bnd_reg.s0_kind;
                m_tdata[31:0] = bnd_reg.s0_data;
            end
            else
            begin
                m_tdata[7:0] = bnd_reg.s1_data;
            end
        end
        else
        begin
            m_tuser         = KIND_SUMMARY;
            m_tlast         = 1'b1;
            m_tdata[31:0]   = bnd_reg.sum.ssrc;
            m_tdata[47:32]  = bnd_reg.sum.seq_num;
            m_tdata[79:48]  = bnd_reg.sum.timestamp;
            m_tdata[86:80]  = bnd_reg.sum.media_type;
            m_tdata[87]     = bnd_reg.sum.marker;
            m_tdata[91:88]  = bnd_reg.sum.source_count;
            m_tdata[92]     = bnd_reg.sum.has_extension;
            m_tdata[93]     = bnd_reg.sum.padded;
            m_tdata[105:94] = bnd_reg.sum.payload_length;
            m_tdata[106]    = bnd_reg.sum.packet_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (bnd_load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (busy_reg && m_tready)
        begin
            if (last_item)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (bnd_load)
        begin
            bnd_reg <= bnd;
        end
    end

endmodule

FILE: rtl/core/rtp_header_parser_unit.sv
// RTP header parser.
// Input stream: one packet octet per transaction, s_tlast on the final octet.
// Output stream: one result per transaction; m_tuser gives the kind (payload
// byte, CSRC word, summary) and m_tlast marks the per-packet summary.
// Config channel: cfg_index selects swap_type_a/b/c (0..2) or swap_enable (3);
// other indexes are ignored. Always ready; write only while the block is idle.
// An octet is captured in the input register, parsed into a result bundle
// that is loaded into the bundle register, and its first result is shown
// from the bundle register.
// Throughput: one octet per cycle, except while an octet with results waits
// for the previous bundle to drain. An octet yields zero to three results;
// the bundle register drains one per cycle while m_tready is high, and
// octets yielding no result are parsed while a bundle drains, so swapped
// payload pairs also run at one octet per cycle. An end octet that closes a
// swapped pair yields three results. m_tready low holds the output register;
// the input side then stalls on the next octet that produces results.
// Reset clears all packet state and loads the config reset values.
module rtp_header_parser_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] byte_value
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] data, [47:32] seq_num, [79:48] timestamp, [86:80] media type,
    // [87] marker, [91:88] source count, [92] has_extension, [93] padded,
    // [105:94] payload_length, [106] packet_valid, [111:107] zero
    output logic [rhp_pkg::OUT_DATA_W-1:0]      m_tdata,
    output rhp_pkg::kind_t                      m_tuser,   // [1:0] kind
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rhp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rhp_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import rhp_pkg::*;

    cfg_t    cfg_reg;
    logic    bnd_load;
    logic    bnd_ready;
    bundle_t bnd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.swap_type_a <= 7'd10;
            cfg_reg.swap_type_b <= 7'd11;
            cfg_reg.swap_type_c <= 7'd11;
            cfg_reg.swap_enable <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SWAP_TYPE_A: cfg_reg.swap_type_a <= cfg_data;
                REG_SWAP_TYPE_B: cfg_reg.swap_type_b <= cfg_data;
                REG_SWAP_TYPE_C: cfg_reg.swap_type_c <= cfg_data;
                REG_SWAP_ENABLE: cfg_reg.swap_enable <= cfg_data[0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    rhp_parse u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_eop    (s_tlast),
        .bnd_load  (bnd_load),
        .bnd_ready (bnd_ready),
        .bnd       (bnd)
    );

    rhp_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .bnd_load  (bnd_load),
        .bnd_ready (bnd_ready),
        .bnd       (bnd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
